### design/crt_pkg.sv
// Shared types and constants for the confirmable retransmit table.
// No dependencies; imported by crt_ctrl, crt_dpath and the top level.
package crt_pkg;

  typedef enum logic [1:0] {
    FUNC_REGISTER,
    FUNC_ACK,
    FUNC_RELEASE,
    FUNC_SCAN
  } func_t;

  localparam logic CFG_BASE_TIMEOUT = 1'b0;
  localparam logic CFG_MAX_TRIES    = 1'b1;

  localparam logic [3:0]  BASE_TIMEOUT_RST = 4'd2;
  localparam logic [2:0]  MAX_TRIES_RST    = 3'd4;
  localparam logic [31:0] SCAN_SLACK_MS    = 32'd60;
  localparam logic [13:0] MS_PER_S         = 14'd1000;

  typedef struct packed {
    func_t       func;
    logic [31:0] now_ms;
    logic [15:0] dest_id;
    logic [15:0] msg_id;
    logic [3:0]  start_tries;
    logic [7:0]  pkt_len;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  slot;
    logic [3:0]  tries_out;
    logic        resend;
    logic [15:0] resend_dest;
    logic [15:0] resend_mid;
    logic [7:0]  resend_len;
    logic        gave_up;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic mark_hit;
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic last;
  } status_t;

endpackage

### design/crt_ctrl.sv
// Sequencer for the retransmit table: accept, slot search, span capture, commit.
// Depends on crt_pkg for the command and status structs.
module crt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  crt_pkg::status_t status,
  output crt_pkg::cmd_t    cmd
);
  import crt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SPAN,
    ST_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.match) begin
          cmd.mark_hit = 1'b1;
          state_next   = ST_SPAN;
        end else if (status.last) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_SPAN: begin
        cmd.capture = 1'b1;
        state_next  = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

### design/crt_dpath.sv
// Slot storage, configuration registers, match logic and result register.
// Depends on crt_pkg; driven by crt_ctrl through cmd_t / status_t.
module crt_dpath #(
  parameter int SLOTS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  crt_pkg::in_t     item,
  input  crt_pkg::cmd_t    cmd,
  output crt_pkg::status_t status,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [3:0]       cfg_data,
  output logic             done,
  output crt_pkg::out_t    result
);
  import crt_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic        armed      [SLOTS];
  logic [15:0] slot_dest  [SLOTS];
  logic [15:0] slot_mid   [SLOTS];
  logic [3:0]  slot_base  [SLOTS];
  logic [3:0]  slot_tries [SLOTS];
  logic [7:0]  slot_len   [SLOTS];
  logic [31:0] slot_deadline [SLOTS];

  logic [3:0]  base_timeout_s;
  logic [2:0]  max_tries;

  in_t         req;
  logic [31:0] limit;
  logic [IW-1:0] idx;
  logic        hit;
  logic [13:0] prod;
  logic [3:0]  tries_inc;

  logic        give_up;
  out_t        res_next;

  always_comb begin
    status.last = (idx == IW'(SLOTS - 1));
    case (req.func)
      FUNC_REGISTER: status.match = (slot_mid[idx] == 16'd0);
      FUNC_ACK,
      FUNC_RELEASE:  status.match = (slot_mid[idx] == req.msg_id);
      FUNC_SCAN:     status.match = armed[idx] && (slot_deadline[idx] <= limit);
      default:       status.match = 1'b0;
    endcase
  end

  assign give_up = (tries_inc == {1'b0, max_tries});

  always_comb begin
    res_next = '0;
    if (hit) begin
      res_next.hit  = 1'b1;
      res_next.slot = 2'(idx);
      case (req.func)
        FUNC_ACK: res_next.tries_out = slot_tries[idx];
        FUNC_SCAN: begin
          res_next.resend      = 1'b1;
          res_next.resend_dest = slot_dest[idx];
          res_next.resend_mid  = slot_mid[idx];
          res_next.resend_len  = slot_len[idx];
          res_next.gave_up     = give_up;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= item;
      limit <= item.now_ms - SCAN_SLACK_MS;
    end
    if (cmd.capture) begin
      prod      <= MS_PER_S * ((req.func == FUNC_REGISTER) ? 14'(base_timeout_s)
                                                           : 14'(slot_base[idx]));
      tries_inc <= slot_tries[idx] + 4'd1;
    end
    if (cmd.commit) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= '{default: '0};
      slot_dest      <= '{default: '0};
      slot_mid       <= '{default: '0};
      slot_base      <= '{default: '0};
      slot_tries     <= '{default: '0};
      slot_len       <= '{default: '0};
      slot_deadline  <= '{default: '0};
      base_timeout_s <= BASE_TIMEOUT_RST;
      max_tries      <= MAX_TRIES_RST;
      idx            <= '0;
      hit            <= 1'b0;
      done           <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_TIMEOUT: base_timeout_s <= cfg_data;
          CFG_MAX_TRIES:    max_tries      <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        idx <= '0;
        hit <= 1'b0;
      end
      if (cmd.step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.mark_hit) begin
        hit <= 1'b1;
      end
      if (cmd.commit && hit) begin
        case (req.func)
          FUNC_REGISTER: begin
            armed[idx]         <= 1'b1;
            slot_dest[idx]     <= req.dest_id;
            slot_mid[idx]      <= req.msg_id;
            slot_base[idx]     <= base_timeout_s;
            slot_tries[idx]    <= req.start_tries;
            slot_len[idx]      <= req.pkt_len;
            slot_deadline[idx] <= req.now_ms + 32'(prod);
          end
          FUNC_ACK: begin
            armed[idx] <= 1'b0;
          end
          FUNC_RELEASE: begin
            armed[idx]      <= 1'b0;
            slot_dest[idx]  <= '0;
            slot_mid[idx]   <= '0;
            slot_base[idx]  <= '0;
            slot_tries[idx] <= '0;
            slot_len[idx]   <= '0;
          end
          FUNC_SCAN: begin
            if (give_up) begin
              armed[idx]      <= 1'b0;
              slot_dest[idx]  <= '0;
              slot_mid[idx]   <= '0;
              slot_base[idx]  <= '0;
              slot_tries[idx] <= '0;
              slot_len[idx]   <= '0;
            end else begin
              slot_tries[idx]    <= tries_inc;
              slot_deadline[idx] <= req.now_ms + (32'(prod) << tries_inc);
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### design/confirmable_retransmit_table.sv
// Retransmission slot table for confirmable messages. A command is taken when
// start is high and busy is low; busy stays high until the result is out. The
// sequencer walks 1 to SLOTS slots, one slot per cycle, until it finds the first
// free, matching or expired slot, then captures the span and commits (a miss
// walks all SLOTS and skips the span cycle). The result appears for exactly one
// cycle with done high and cannot be stalled; the receiver must capture it then.
// Configuration writes are always ready and should be issued only while busy is
// low. Depends on crt_pkg, crt_ctrl, crt_dpath.
module confirmable_retransmit_table #(
  parameter int SLOTS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  crt_pkg::in_t  item,
  output logic          done,
  output crt_pkg::out_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [3:0]    cfg_data
);
  import crt_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  crt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  crt_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done)
    else $error("commit did not produce a result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.slot == 2'd0 && !result.resend && !result.gave_up
      && result.tries_out == 4'd0)
    else $error("miss result carries nonzero fields");

  a_gave_up_resend: assert property (@(posedge clk) disable iff (rst)
    done && result.gave_up |-> result.resend && result.hit)
    else $error("give-up without resend");
`endif

endmodule
